@@ design/ibcd_pkg.sv @@
package ibcd_pkg;

  localparam int BLOCK_W = 64;
  localparam int BYTE_W  = 8;
  localparam int ROWS    = 8;
  localparam int WORD_W  = 16;
  localparam int CMP_W   = 15;
  localparam int WORDS   = 4;
  localparam int CODES   = 4;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [1:0]         code_idx_t;
  typedef logic [3:0]         dist_t;
  typedef logic [4:0]         best_dist_t;

  localparam word_t CODEBOOK [CODES] = '{16'h0000, 16'h3333, 16'h5555, 16'h6666};

  // Position p is numbered from the top bit down; output position 8r+c takes
  // input position 8c+r.
  function automatic block_t transpose8x8(block_t x);
    block_t y;
    y = '0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < ROWS; c++) begin
        y[BLOCK_W-1-(ROWS*r+c)] = x[BLOCK_W-1-(ROWS*c+r)];
      end
    end
    return y;
  endfunction

  function automatic dist_t weight15(word_t v);
    dist_t n;
    n = '0;
    for (int k = 0; k < CMP_W; k++) begin
      n = n + dist_t'(v[k]);
    end
    return n;
  endfunction

  // Nearest codeword by distance over the low 15 bits; a tie keeps the lower index.
  function automatic code_idx_t nearest(word_t w);
    code_idx_t  best;
    best_dist_t bestd;
    dist_t      d;
    best  = '0;
    bestd = 5'd16;
    for (int j = 0; j < CODES; j++) begin
      d = weight15(w ^ CODEBOOK[j]);
      if (best_dist_t'(d) < bestd) begin
        bestd = best_dist_t'(d);
        best  = code_idx_t'(j);
      end
    end
    return best;
  endfunction

  function automatic byte_t decode_block(block_t x);
    block_t t;
    byte_t  res;
    t   = transpose8x8(x);
    res = '0;
    for (int i = 0; i < WORDS; i++) begin
      res[2*i +: 2] = nearest(t[BLOCK_W-1-WORD_W*i -: WORD_W]);
    end
    return res;
  endfunction

endpackage

@@ design/ibcd_if.sv @@
interface ibcd_block_if;
  logic                  valid;
  logic                  ready;
  ibcd_pkg::block_t      received_block;

  modport source(output valid, output received_block, input ready);
  modport sink(input valid, input received_block, output ready);
endinterface

interface ibcd_byte_if;
  logic                  valid;
  logic                  ready;
  ibcd_pkg::byte_t       decoded_byte;

  modport source(output valid, output decoded_byte, input ready);
  modport sink(input valid, input decoded_byte, output ready);
endinterface

@@ design/interleaved_block_code_decoder.sv @@
// Interleaved block decoder: each 64-bit received block (byte 0 in the top
// bits) is de-interleaved by an 8x8 bit transpose, split into four 16-bit
// words, and each word is mapped to the nearest of four fixed codewords by
// Hamming distance over its low 15 bits (ties go to the lower index). The
// four 2-bit winners form one decoded byte, word i in bits 2i+1..2i. The
// block accepts one transaction per cycle unless the sink stalls, and
// delivers each result through an input register and a result register; the decode logic
// between them is the whole datapath. No state is kept between blocks, and
// reset only empties the two register stages.
module interleaved_block_code_decoder (
  input  logic                clk,
  input  logic                rst,
  ibcd_block_if.sink          received,
  ibcd_byte_if.source         decoded
);

  // Stage 1: captured received block.
  logic                 stage_valid;
  ibcd_pkg::block_t     stage_block;

  // Stage 2: decoded byte waiting for the sink.
  logic                 out_valid;
  ibcd_pkg::byte_t      out_byte;

  logic                 out_load;
  logic                 stage_adv;

  // Load the result register when empty or being drained this cycle.
  assign out_load  = !out_valid || decoded.ready;
  // Advance the input register whenever its content moves on or it is empty.
  assign stage_adv = !stage_valid || out_load;

  assign received.ready       = stage_adv;
  assign decoded.valid        = out_valid;
  assign decoded.decoded_byte = out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (stage_adv) begin
        stage_valid <= received.valid;
      end
      if (out_load) begin
        out_valid <= stage_valid;
      end
    end
  end

  // Payload registers: hold while stalled, no reset needed.
  always_ff @(posedge clk) begin
    if (stage_adv && received.valid) begin
      stage_block <= received.received_block;
    end
    if (out_load && stage_valid) begin
      out_byte <= ibcd_pkg::decode_block(stage_block);
    end
  end

endmodule

@@ design/ibcd_checker.sv @@
module ibcd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input ibcd_pkg::byte_t      out_byte
);

  // A result waiting for the sink stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("decoded transaction dropped while stalled");

  // A stalled result keeps its value.
  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("decoded byte changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // With the sink ready, the block never stalls its source.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // No result without a prior input transaction once reset is gone.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !$past(in_valid) && !$past(in_valid, 2) && !$past(out_valid) && !$past(rst)
      && !$past(rst, 2) |-> !out_valid)
    else $error("result appeared without an input transaction");

endmodule

bind interleaved_block_code_decoder ibcd_checker u_ibcd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (received.valid),
  .in_ready  (received.ready),
  .out_valid (decoded.valid),
  .out_ready (decoded.ready),
  .out_byte  (decoded.decoded_byte)
);
